// ----- rtl/core/hbd_pkg.sv -----
package hbd_pkg;

  // Register codes for decode_mode; the fourth code behaves as copy
  localparam logic [1:0] MODE_COPY = 2'd0;
  localparam logic [1:0] MODE_HEX  = 2'd1;
  localparam logic [1:0] MODE_B64  = 2'd2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Base64 alphabet offsets
  localparam logic [7:0] B64_LOWER_BASE = 8'd26;
  localparam logic [7:0] B64_DIGIT_BASE = 8'd52;
  localparam logic [5:0] B64_PLUS_VAL   = 6'd62;
  localparam logic [5:0] B64_SLASH_VAL  = 6'd63;
  localparam logic [7:0] BYTE_MAX       = 8'hFF;

  // How the back end handles one queued item
  typedef enum logic [1:0] {
    OP_COPY,
    OP_HEX,
    OP_B64
  } op_t;

  // One classified character
  typedef struct packed {
    op_t        op;
    logic       val_ok;   // digit or sextet is valid (always 1 for copy)
    logic [7:0] val;      // char for copy, digit for hex, sextet for base64
    logic       last;
  } cls_t;

  // Hex digit lookup: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

  // Base64 alphabet lookup: {valid, sextet}
  function automatic logic [6:0] b64_sextet(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - "A")};
    end else if (c >= "a" && c <= "z") begin
      r = {1'b1, 6'(c - "a" + B64_LOWER_BASE)};
    end else if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c - "0" + B64_DIGIT_BASE)};
    end else if (c == "+") begin
      r = {1'b1, B64_PLUS_VAL};
    end else if (c == "/") begin
      r = {1'b1, B64_SLASH_VAL};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/hbd_if.sv -----
// Character channel
interface hbd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, output text_char, output last_char, input ready);
  modport sink (input valid, input text_char, input last_char, output ready);
endinterface

// Decoded byte channel
interface hbd_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_string;
  logic [15:0] byte_count;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_string, output byte_count, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_string, input byte_count, output ready);
endinterface

// ----- rtl/core/hex_base64_text_decoder.sv -----
// Channel    Dir   Handshake      Payload
// char_ch    in    valid/ready    text_char[7:0], last_char
// byte_ch    out   valid/ready    data_byte[7:0], byte_valid, end_of_string, byte_count[15:0]
// cfg        in    cfg_we         cfg_wdata[1:0] (decode_mode)
//
// One character per cycle sustained while byte_ch does not stall; each
// result is held first in the four-entry queue and then in the back end's
// output register.
// rst is synchronous and clears the mode to copy and all string state.
// char_ch.ready drops only when the queue is full; byte_ch stalls hold the
// output register and let the queue fill.
module hex_base64_text_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  hbd_char_if.sink   char_ch,
  hbd_byte_if.source byte_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);
  import hbd_pkg::*;

  logic push;
  cls_t push_item;
  logic q_full;
  logic q_valid;
  cls_t q_item;
  logic pop;

  hbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_ch   (char_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  hbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hbd_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop),
    .byte_ch (byte_ch)
  );

  // A result that does not close a string always carries a byte
  assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && !byte_ch.end_of_string |-> byte_ch.byte_valid)
    else $error("open result without a byte");

  // Counts appear only on closing results
  assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && !byte_ch.end_of_string |-> byte_ch.byte_count == 16'd0)
    else $error("byte count on open result");

  // An empty result carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && !byte_ch.byte_valid |-> byte_ch.data_byte == 8'd0)
    else $error("data without byte_valid");

  // Input stalls only while the queue holds items
  assert property (@(posedge clk) disable iff (rst)
    !char_ch.ready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule

// ----- rtl/core/hbd_front.sv -----
module hbd_front (
  input  logic          clk,
  input  logic          rst,
  hbd_char_if.sink      char_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_wdata,
  input  logic          q_full,
  output logic          push,
  output hbd_pkg::cls_t push_item
);
  import hbd_pkg::*;

  logic [1:0] mode;
  logic [4:0] hex_res;
  logic [6:0] b64_res;

  // Hold the decode mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_COPY;
    end else if (cfg_we) begin
      mode <= cfg_wdata;
    end
  end

  // Accept whenever the queue has room
  assign char_ch.ready = !q_full;
  assign push          = char_ch.valid && !q_full;

  // Classify the character under the current mode
  always_comb begin
    hex_res = hex_digit(char_ch.text_char);
    b64_res = b64_sextet(char_ch.text_char);
    push_item.last = char_ch.last_char;
    unique case (mode)
      MODE_HEX: begin
        push_item.op     = OP_HEX;
        push_item.val_ok = hex_res[4];
        push_item.val    = {4'd0, hex_res[3:0]};
      end
      MODE_B64: begin
        push_item.op     = OP_B64;
        push_item.val_ok = b64_res[6];
        push_item.val    = {2'd0, b64_res[5:0]};
      end
      default: begin
        push_item.op     = OP_COPY;
        push_item.val_ok = 1'b1;
        push_item.val    = char_ch.text_char;
      end
    endcase
  end

endmodule

// ----- rtl/core/hbd_queue.sv -----
module hbd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hbd_pkg::cls_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output hbd_pkg::cls_t q_item
);
  import hbd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] level;

  assign full    = (level == CW'(DEPTH));
  assign q_valid = (level != '0);
  assign q_item  = slots[rd_ptr];

  // Write the incoming item
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/hbd_back.sv -----
module hbd_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  hbd_pkg::cls_t q_item,
  output logic          pop,
  hbd_byte_if.source    byte_ch
);
  import hbd_pkg::*;

  localparam int WW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [3:0]            high_nibble, high_nibble_next;
  logic                  nibble_pending, nibble_pending_next;
  logic                  hex_stopped, hex_stopped_next;
  logic [11:0]           bit_accumulator, bit_accumulator_next;
  logic [3:0]            bits_held, bits_held_next;
  logic [COUNT_BITS-1:0] bytes_emitted, bytes_emitted_next;

  logic                  have;
  logic [7:0]            dec_byte;
  logic [3:0]            bits_sum;
  logic [11:0]           acc_shift;
  logic [WW-1:0]         cnt_wide;
  logic [15:0]           cnt_sat;
  logic                  emit;

  // Pop when the output register is free or being emptied
  assign pop  = q_valid && (!byte_ch.valid || byte_ch.ready);
  assign emit = pop && (have || q_item.last);

  // Decode the item and compute the next string state
  always_comb begin
    high_nibble_next     = high_nibble;
    nibble_pending_next  = nibble_pending;
    hex_stopped_next     = hex_stopped;
    bit_accumulator_next = bit_accumulator;
    bits_held_next       = bits_held;
    have                 = 1'b0;
    dec_byte             = '0;
    bits_sum             = bits_held + 4'd6;
    acc_shift            = {bit_accumulator[5:0], q_item.val[5:0]};
    unique case (q_item.op)
      OP_HEX: begin
        if (!hex_stopped) begin
          if (!nibble_pending) begin
            if (!q_item.val_ok) begin
              hex_stopped_next = 1'b1;
            end else begin
              high_nibble_next    = q_item.val[3:0];
              nibble_pending_next = 1'b1;
            end
          end else begin
            nibble_pending_next = 1'b0;
            if (!q_item.val_ok) begin
              hex_stopped_next = 1'b1;
            end else begin
              dec_byte = {high_nibble, q_item.val[3:0]};
              have     = 1'b1;
            end
          end
        end
      end
      OP_B64: begin
        if (q_item.val_ok) begin
          bit_accumulator_next = acc_shift;
          if (bits_sum >= 4'd8) begin
            bits_held_next = bits_sum - 4'd8;
            dec_byte       = 8'(acc_shift >> (bits_sum - 4'd8)) & BYTE_MAX;
            have           = 1'b1;
          end else begin
            bits_held_next = bits_sum;
          end
        end
      end
      default: begin
        dec_byte = q_item.val;
        have     = 1'b1;
      end
    endcase

    bytes_emitted_next = bytes_emitted;
    if (have && (bytes_emitted != '1)) begin
      bytes_emitted_next = bytes_emitted + 1'b1;
    end
    cnt_wide = WW'(bytes_emitted_next);
    cnt_sat  = (cnt_wide > WW'(16'hFFFF)) ? 16'hFFFF : cnt_wide[15:0];
  end

  // Update string state; clear it after the closing item
  always_ff @(posedge clk) begin
    if (rst) begin
      high_nibble     <= '0;
      nibble_pending  <= 1'b0;
      hex_stopped     <= 1'b0;
      bit_accumulator <= '0;
      bits_held       <= '0;
      bytes_emitted   <= '0;
    end else if (pop) begin
      if (q_item.last) begin
        high_nibble     <= '0;
        nibble_pending  <= 1'b0;
        hex_stopped     <= 1'b0;
        bit_accumulator <= '0;
        bits_held       <= '0;
        bytes_emitted   <= '0;
      end else begin
        high_nibble     <= high_nibble_next;
        nibble_pending  <= nibble_pending_next;
        hex_stopped     <= hex_stopped_next;
        bit_accumulator <= bit_accumulator_next;
        bits_held       <= bits_held_next;
        bytes_emitted   <= bytes_emitted_next;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else if (pop) begin
      byte_ch.valid <= have || q_item.last;
    end else if (byte_ch.ready) begin
      byte_ch.valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      byte_ch.data_byte     <= have ? dec_byte : 8'd0;
      byte_ch.byte_valid    <= have;
      byte_ch.end_of_string <= q_item.last;
      byte_ch.byte_count    <= q_item.last ? cnt_sat : 16'd0;
    end
  end

endmodule

// ----- verif/tb_hex_base64_text_decoder.sv -----
`timescale 1ns / 1ps

module tb_hex_base64_text_decoder;
  import hbd_pkg::*;

  // The fourth mode code decodes as copy
  localparam logic [1:0] MODE_ALT_COPY = 2'd3;
  // Quiet cycles before a mode write once all results are in
  localparam int SETTLE_CYCLES = 10;
  // Cycles with no handshake before the run is abandoned
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 1700;

  // One planned step: a character item or a mode write
  typedef struct {
    logic       is_cfg;
    logic [1:0] mode;
    logic [7:0] ch;
    logic       lst;
  } plan_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        end_of_string;
    logic [15:0] byte_count;
  } byte_res_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  hbd_char_if char_ch();
  hbd_byte_if byte_ch();

  hex_base64_text_decoder #(.COUNT_BITS(16)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .char_ch   (char_ch),
    .byte_ch   (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  plan_t     char_plan[$];
  byte_res_t expected_bytes[$];
  int        mismatches;

  // Decoder state as predicted on the input side
  logic [1:0]  cur_mode;
  logic [3:0]  hi_nib;
  logic        nib_pend;
  logic        hex_halt;
  logic [11:0] acc;
  logic [3:0]  nbits;
  logic [15:0] nbytes;

  // Clock and reset
  initial begin
    clk = 1'b0;
  end
  always #5 clk = ~clk;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = MODE_COPY;
    char_ch.valid = 1'b0;
    char_ch.text_char = '0;
    char_ch.last_char = 1'b0;
    byte_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic int sextet_value(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  task automatic clear_string_state();
    hi_nib = '0;
    nib_pend = 1'b0;
    hex_halt = 1'b0;
    acc = '0;
    nbits = '0;
    nbytes = '0;
  endtask

  // Predict the result of one accepted character
  task automatic decode_char(input logic [7:0] c, input logic lst);
    int          d;
    logic        have;
    logic [7:0]  val;
    logic [11:0] acc_n;
    logic [4:0]  bits_n;
    byte_res_t   r;
    have = 1'b0;
    val = '0;
    case (cur_mode)
      MODE_HEX: begin
        d = hex_value(c);
        if (!hex_halt) begin
          if (!nib_pend) begin
            if (d < 0) begin
              hex_halt = 1'b1;
            end else begin
              hi_nib = d[3:0];
              nib_pend = 1'b1;
            end
          end else begin
            nib_pend = 1'b0;
            if (d < 0) begin
              hex_halt = 1'b1;
            end else begin
              val = {hi_nib, d[3:0]};
              have = 1'b1;
            end
          end
        end
      end
      MODE_B64: begin
        d = sextet_value(c);
        if (d >= 0) begin
          acc_n = {acc[5:0], d[5:0]};
          bits_n = {1'b0, nbits} + 5'd6;
          if (bits_n >= 5'd8) begin
            bits_n = bits_n - 5'd8;
            val = 8'(acc_n >> bits_n);
            have = 1'b1;
          end
          acc = acc_n;
          nbits = bits_n[3:0];
        end
      end
      default: begin
        val = c;
        have = 1'b1;
      end
    endcase

    // Saturate the byte count
    if (have && nbytes != 16'hFFFF) nbytes = nbytes + 16'd1;

    if (lst) begin
      r = '{data_byte: have ? val : 8'd0, byte_valid: have, end_of_string: 1'b1,
            byte_count: nbytes};
      expected_bytes.push_back(r);
      clear_string_state();
    end else if (have) begin
      r = '{data_byte: val, byte_valid: 1'b1, end_of_string: 1'b0, byte_count: 16'd0};
      expected_bytes.push_back(r);
    end
  endtask

  // Plan building
  task automatic plan_char(input logic [7:0] c, input logic lst);
    char_plan.push_back('{is_cfg: 1'b0, mode: 2'd0, ch: c, lst: lst});
  endtask

  task automatic plan_mode(input logic [1:0] m);
    char_plan.push_back('{is_cfg: 1'b1, mode: m, ch: 8'd0, lst: 1'b0});
  endtask

  task automatic plan_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      plan_char(s[i], close && (i == s.len() - 1));
    end
  endtask

  // Mostly well-formed characters for the mode, with some noise
  function automatic logic [7:0] pick_char(input logic [1:0] m);
    string hex_set;
    string b64_set;
    string junk_set;
    hex_set = "0123456789abcdefABCDEF";
    b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    junk_set = "=\n\r \t";
    case (m)
      MODE_HEX: begin
        if ($urandom_range(0, 19) != 0) return hex_set[$urandom_range(0, hex_set.len() - 1)];
        return 8'($urandom_range(0, 255));
      end
      MODE_B64: begin
        if ($urandom_range(0, 19) < 17) return b64_set[$urandom_range(0, b64_set.len() - 1)];
        if ($urandom_range(0, 1) != 0) return junk_set[$urandom_range(0, junk_set.len() - 1)];
        return 8'($urandom_range(0, 255));
      end
      default: begin
        if ($urandom_range(0, 49) == 0) return 8'd0;
        return 8'($urandom_range(1, 255));
      end
    endcase
  endfunction

  task automatic plan_string(input logic [1:0] m, input int len, input logic close);
    for (int i = 0; i < len; i++) begin
      plan_char(pick_char(m), close && (i == len - 1));
    end
  endtask

  // Fill the plan, then wait for the drain and report
  initial begin
    int         planned;
    int         nstr;
    int         len;
    logic [1:0] m;
    logic       close;
    logic       open_str;

    mismatches = 0;

    // Copy: zero code and top code
    plan_mode(MODE_COPY);
    plan_char("A", 1'b0);
    plan_char(8'h00, 1'b0);
    plan_char(8'hFF, 1'b1);
    // Hex: both cases, odd trailing digit, invalid digit, invalid left at end
    plan_mode(MODE_HEX);
    plan_text("aF09F", 1'b1);
    plan_text("1g2", 1'b1);
    plan_text("Abx", 1'b1);
    // Base64: padding, whitespace, plus and slash, byte on the closing item
    plan_mode(MODE_B64);
    plan_text("TWE=\n", 1'b1);
    plan_text("+/\t9z", 1'b1);
    // Fourth mode code
    plan_mode(MODE_ALT_COPY);
    plan_char("q", 1'b1);
    // Mode changes within one string keep the hex digit pending
    plan_mode(MODE_HEX);
    plan_char("4", 1'b0);
    plan_mode(MODE_COPY);
    plan_char("x", 1'b0);
    plan_mode(MODE_HEX);
    plan_char("2", 1'b1);

    // Random phases of strings, some left open across a mode change
    planned = 0;
    open_str = 1'b0;
    m = MODE_COPY;
    while (planned < RANDOM_ITEMS) begin
      m = 2'($urandom_range(0, 3));
      plan_mode(m);
      nstr = $urandom_range(1, 8);
      for (int s = 0; s < nstr; s++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        close = !((s == nstr - 1) && ($urandom_range(0, 4) == 0));
        plan_string(m, len, close);
        open_str = !close;
        planned += len;
      end
    end
    if (open_str) plan_char(pick_char(m), 1'b1);

    @(negedge rst);
    do begin
      @(posedge clk);
    end while (char_plan.size() != 0 || expected_bytes.size() != 0);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: bursts of items, random gaps, mode writes once drained
  int burst_left;
  int gap_left;
  int settle;

  always @(posedge clk) begin
    logic nxt_valid;
    logic nxt_we;
    if (rst) begin
      char_ch.valid <= 1'b0;
      cfg_we <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
      settle = 0;
      cur_mode = MODE_COPY;
      clear_string_state();
    end else begin
      nxt_valid = char_ch.valid;
      nxt_we = 1'b0;
      if (char_ch.valid && char_ch.ready) begin
        decode_char(char_ch.text_char, char_ch.last_char);
        void'(char_plan.pop_front());
        nxt_valid = 1'b0;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_plan.size() != 0) begin
          if (!char_plan[0].is_cfg) begin
            char_ch.text_char <= char_plan[0].ch;
            char_ch.last_char <= char_plan[0].lst;
            nxt_valid = 1'b1;
          end else if (expected_bytes.size() == 0 && !cfg_we) begin
            // Hold the write until ignored characters have drained
            if (settle < SETTLE_CYCLES) begin
              settle++;
            end else begin
              nxt_we = 1'b1;
              cfg_wdata <= char_plan[0].mode;
              cur_mode = char_plan[0].mode;
              void'(char_plan.pop_front());
              settle = 0;
            end
          end else begin
            settle = 0;
          end
        end
      end
      char_ch.valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // Receiver stall pattern: switch among four randomly chosen styles
  int stall_style;
  int style_left;
  int tick;

  always @(posedge clk) begin
    logic rdy;
    if (rst) begin
      byte_ch.ready <= 1'b0;
      stall_style = 0;
      style_left = 0;
      tick = 0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(100, 600);
      end else begin
        style_left--;
      end
      case (stall_style)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 9) < 3);
        default: rdy = ((tick % 8) >= 3);
      endcase
      tick++;
      byte_ch.ready <= rdy;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    byte_res_t exp_r;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: data_byte %0h byte_valid %0b end_of_string %0b count %0d",
               byte_ch.data_byte, byte_ch.byte_valid, byte_ch.end_of_string,
               byte_ch.byte_count);
        mismatches++;
      end else begin
        exp_r = expected_bytes.pop_front();
        if (byte_ch.data_byte !== exp_r.data_byte) begin
          $error("data_byte: expected %0h, got %0h", exp_r.data_byte, byte_ch.data_byte);
          mismatches++;
        end
        if (byte_ch.byte_valid !== exp_r.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", exp_r.byte_valid, byte_ch.byte_valid);
          mismatches++;
        end
        if (byte_ch.end_of_string !== exp_r.end_of_string) begin
          $error("end_of_string: expected %0b, got %0b", exp_r.end_of_string,
                 byte_ch.end_of_string);
          mismatches++;
        end
        if (byte_ch.byte_count !== exp_r.byte_count) begin
          $error("byte_count: expected %0d, got %0d", exp_r.byte_count, byte_ch.byte_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: abandon the run after a long stretch with no handshake
  int quiet;

  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((char_ch.valid && char_ch.ready) || (byte_ch.valid && byte_ch.ready) ||
                 cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule

// ----- filelist.f -----
rtl/core/hbd_pkg.sv
rtl/core/hbd_if.sv
rtl/core/hbd_front.sv
rtl/core/hbd_queue.sv
rtl/core/hbd_back.sv
rtl/core/hex_base64_text_decoder.sv
verif/tb_hex_base64_text_decoder.sv
